// File: rtl/core/gdcb_pkg.sv
// ----------------------------------------------------------------------------
// Grid density cull bias package
// Shared types, widths, codes and reset values for the cull bias core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdcb_pkg;

  // Default structure sizes.
  localparam int GRID_SIDE_DEF   = 128;
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths.
  localparam int DIVIDEND_W = 32;
  localparam int CELL_W     = 16;
  localparam int THR_W      = 20;
  localparam int DIST_W     = 24;
  localparam int BIAS_W     = 10;
  localparam int LCOUNT_W   = 20;
  localparam int COORD_W    = 7;

  // Divider steps per query: one quotient bit per cycle.
  localparam int DIV_STEPS = DIVIDEND_W;

  // Bias values in Q8.
  localparam logic [BIAS_W-1:0] BIAS_ONE  = 10'd256;
  localparam logic [BIAS_W-1:0] BIAS_NEAR = 10'd410;
  localparam logic [BIAS_W-1:0] BIAS_FAR  = 10'd640;

  localparam logic [LCOUNT_W-1:0] LCOUNT_MAX = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE   = 3'd0,
    CFG_THRESHOLD   = 3'd1,
    CFG_FAR_DIST    = 3'd2,
    CFG_NEAR_DIST   = 3'd3
  } cfg_reg_e;

  localparam logic [CELL_W-1:0] CELL_SIZE_RST = 16'd160;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 20'd30;
  localparam logic [DIST_W-1:0] FAR_DIST_RST  = 24'd640;
  localparam logic [DIST_W-1:0] NEAR_DIST_RST = 24'd320;

  // Item kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Neighbour offset codes along one axis.
  localparam logic [1:0] NBR_MINUS  = 2'd0;
  localparam logic [1:0] NBR_CENTER = 2'd1;
  localparam logic [1:0] NBR_PLUS   = 2'd2;

  typedef struct packed {
    logic                         kind;
    logic signed [DIVIDEND_W-1:0] player_x;
    logic signed [DIVIDEND_W-1:0] player_y;
    logic [DIST_W-1:0]            distance;
  } in_item_t;

  typedef struct packed {
    logic [BIAS_W-1:0]   bias_q8;
    logic [LCOUNT_W-1:0] local_count;
    logic [COORD_W-1:0]  target_col;
    logic [COORD_W-1:0]  target_row;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FOLD,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_RESULT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       fold;
    logic       rd_en;
    logic [1:0] nbr_dx;
    logic [1:0] nbr_dy;
    logic       wr_inc;
    logic       clr_en;
    logic       out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/gdcb_div_lane.sv
// ----------------------------------------------------------------------------
// Divider lane
// Restoring divider, one quotient bit per step, that folds the quotient
// modulo the grid side as its bits come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdcb_div_lane #(
  parameter int GRID_SIDE = gdcb_pkg::GRID_SIDE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            load_i,
  input  wire logic                            step_i,
  input  wire logic [gdcb_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire logic [gdcb_pkg::CELL_W-1:0]     divisor_i,
  output logic [$clog2(GRID_SIDE)-1:0]         mod_o
);

  localparam int IDX_W = $clog2(GRID_SIDE);

  logic [gdcb_pkg::DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [gdcb_pkg::CELL_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]                mod_q, mod_d;
  logic [gdcb_pkg::CELL_W:0]       rem2, diff;
  logic                            ge;
  logic [IDX_W:0]                  mod2;

  always_comb begin
    rem2 = {rem_q, dvd_q[gdcb_pkg::DIVIDEND_W-1]};
    diff = rem2 - {1'b0, divisor_i};
    ge   = rem2 >= {1'b0, divisor_i};
    mod2 = {mod_q, ge};
    dvd_d = dvd_q;
    rem_d = rem_q;
    mod_d = mod_q;
    if (load_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      mod_d = '0;
    end else if (step_i) begin
      dvd_d = {dvd_q[gdcb_pkg::DIVIDEND_W-2:0], 1'b0};
      rem_d = ge ? diff[gdcb_pkg::CELL_W-1:0] : rem2[gdcb_pkg::CELL_W-1:0];
      // The running quotient stays reduced: twice a residue plus one is
      // below twice the grid side, so one subtract is enough.
      if (mod2 >= (IDX_W+1)'(GRID_SIDE)) begin
        mod_d = IDX_W'(mod2 - (IDX_W+1)'(GRID_SIDE));
      end else begin
        mod_d = mod2[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign mod_o = mod_q;

endmodule

`default_nettype wire

// File: rtl/core/gdcb_ctrl.sv
// ----------------------------------------------------------------------------
// Cull bias controller
// Sequences clearing sweeps, division, neighbour reads, the counter update
// and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdcb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_kind_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire gdcb_pkg::dp_sts_t sts_i,
  output gdcb_pkg::dp_cmd_t      cmd_o
);

  localparam int DCNT_W = $clog2(gdcb_pkg::DIV_STEPS);

  gdcb_pkg::ctrl_state_e state_q, state_d;
  logic [DCNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic [1:0]            nbr_x_q, nbr_x_d, nbr_y_q, nbr_y_d;
  logic                  out_valid_q, out_valid_d;
  logic                  div_last, nbr_last, out_free;

  assign div_last = div_cnt_q == DCNT_W'(gdcb_pkg::DIV_STEPS - 1);
  assign nbr_last = (nbr_x_q == gdcb_pkg::NBR_PLUS) && (nbr_y_q == gdcb_pkg::NBR_PLUS);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdcb_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = gdcb_pkg::ST_IDLE;
      end
      gdcb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == gdcb_pkg::KIND_QUERY) ? gdcb_pkg::ST_DIV
                                                        : gdcb_pkg::ST_CLEAR;
        end
      end
      gdcb_pkg::ST_DIV: begin
        if (div_last) state_d = gdcb_pkg::ST_FOLD;
      end
      gdcb_pkg::ST_FOLD:  state_d = gdcb_pkg::ST_READ;
      gdcb_pkg::ST_READ: begin
        if (nbr_last) state_d = gdcb_pkg::ST_WAIT;
      end
      gdcb_pkg::ST_WAIT:  state_d = gdcb_pkg::ST_WRITE;
      gdcb_pkg::ST_WRITE: state_d = gdcb_pkg::ST_RESULT;
      gdcb_pkg::ST_RESULT: begin
        if (out_free) state_d = gdcb_pkg::ST_IDLE;
      end
      default: state_d = gdcb_pkg::ST_IDLE;
    endcase
  end

  // Counters and output valid.
  always_comb begin
    div_cnt_d = '0;
    nbr_x_d   = gdcb_pkg::NBR_MINUS;
    nbr_y_d   = gdcb_pkg::NBR_MINUS;
    if (state_q == gdcb_pkg::ST_DIV && !div_last) begin
      div_cnt_d = div_cnt_q + DCNT_W'(1);
    end
    if (state_q == gdcb_pkg::ST_READ && !nbr_last) begin
      if (nbr_y_q == gdcb_pkg::NBR_PLUS) begin
        nbr_x_d = nbr_x_q + 2'd1;
      end else begin
        nbr_x_d = nbr_x_q;
        nbr_y_d = nbr_y_q + 2'd1;
      end
    end
    out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == gdcb_pkg::ST_IDLE) && in_valid_i;
    cmd_o.div_step = state_q == gdcb_pkg::ST_DIV;
    cmd_o.fold     = state_q == gdcb_pkg::ST_FOLD;
    cmd_o.rd_en    = state_q == gdcb_pkg::ST_READ;
    cmd_o.nbr_dx   = nbr_x_q;
    cmd_o.nbr_dy   = nbr_y_q;
    cmd_o.wr_inc   = state_q == gdcb_pkg::ST_WRITE;
    cmd_o.clr_en   = state_q == gdcb_pkg::ST_CLEAR;
    cmd_o.out_load = (state_q == gdcb_pkg::ST_RESULT) && out_free;
    in_stall_o     = state_q != gdcb_pkg::ST_IDLE;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdcb_pkg::ST_CLEAR;
      div_cnt_q   <= '0;
      nbr_x_q     <= gdcb_pkg::NBR_MINUS;
      nbr_y_q     <= gdcb_pkg::NBR_MINUS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      nbr_x_q     <= nbr_x_d;
      nbr_y_q     <= nbr_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result never overwrites one that is still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled beat");

  // A finished clearing sweep returns to idle.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdcb_pkg::ST_CLEAR && sts_i.clr_last) |=> state_q == gdcb_pkg::ST_IDLE)
    else $error("clearing sweep did not finish");

  // An accepted query always starts the divider.
  a_query_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && in_kind_i == gdcb_pkg::KIND_QUERY) |=> state_q == gdcb_pkg::ST_DIV)
    else $error("query did not start division");

endmodule

`default_nettype wire

// File: rtl/core/gdcb_datapath.sv
// ----------------------------------------------------------------------------
// Cull bias datapath
// Configuration registers, divider lanes, cell counter memory, neighbourhood
// accumulator and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdcb_datapath #(
  parameter int GRID_SIDE   = gdcb_pkg::GRID_SIDE_DEF,
  parameter int COUNT_WIDTH = gdcb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gdcb_pkg::dp_cmd_t   cmd_i,
  output gdcb_pkg::dp_sts_t        sts_o,
  input  wire gdcb_pkg::cfg_wr_t   cfg_i,
  input  wire gdcb_pkg::in_item_t  in_item_i,
  output gdcb_pkg::out_item_t      out_item_o
);

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = COUNT_WIDTH + 4;
  localparam int CMP_W  = (SUM_W > gdcb_pkg::LCOUNT_W) ? SUM_W : gdcb_pkg::LCOUNT_W;

  // Configuration registers.
  logic [gdcb_pkg::CELL_W-1:0] cell_pitch_q;
  logic [gdcb_pkg::THR_W-1:0]  threshold_q;
  logic [gdcb_pkg::DIST_W-1:0] far_dist_q, near_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_pitch_q <= gdcb_pkg::CELL_SIZE_RST;
      threshold_q  <= gdcb_pkg::THRESHOLD_RST;
      far_dist_q   <= gdcb_pkg::FAR_DIST_RST;
      near_dist_q  <= gdcb_pkg::NEAR_DIST_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        gdcb_pkg::CFG_CELL_SIZE: cell_pitch_q <= cfg_i.data[gdcb_pkg::CELL_W-1:0];
        gdcb_pkg::CFG_THRESHOLD: threshold_q  <= cfg_i.data[gdcb_pkg::THR_W-1:0];
        gdcb_pkg::CFG_FAR_DIST:  far_dist_q   <= cfg_i.data;
        gdcb_pkg::CFG_NEAR_DIST: near_dist_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input capture and divider lanes.
  logic [gdcb_pkg::CELL_W-1:0]     divisor;
  logic [gdcb_pkg::DIVIDEND_W-1:0] mag_x, mag_y, dist_ext;
  logic                            neg_x_q, neg_y_q;
  logic [gdcb_pkg::DIST_W-1:0]     dist_q;
  logic [IDX_W-1:0]                mod_x, mod_y, mod_d;

  // A zero cell size divides as one.
  assign divisor  = (cell_pitch_q == '0) ? gdcb_pkg::CELL_W'(1) : cell_pitch_q;
  assign mag_x    = in_item_i.player_x[gdcb_pkg::DIVIDEND_W-1]
                  ? gdcb_pkg::DIVIDEND_W'(0) - unsigned'(in_item_i.player_x)
                  : unsigned'(in_item_i.player_x);
  assign mag_y    = in_item_i.player_y[gdcb_pkg::DIVIDEND_W-1]
                  ? gdcb_pkg::DIVIDEND_W'(0) - unsigned'(in_item_i.player_y)
                  : unsigned'(in_item_i.player_y);
  assign dist_ext = gdcb_pkg::DIVIDEND_W'(in_item_i.distance);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_x_q <= in_item_i.player_x[gdcb_pkg::DIVIDEND_W-1];
      neg_y_q <= in_item_i.player_y[gdcb_pkg::DIVIDEND_W-1];
      dist_q  <= in_item_i.distance;
    end
  end

  gdcb_div_lane #(.GRID_SIDE(GRID_SIDE)) u_lane_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_x),
    .divisor_i  (divisor),
    .mod_o      (mod_x)
  );

  gdcb_div_lane #(.GRID_SIDE(GRID_SIDE)) u_lane_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_y),
    .divisor_i  (divisor),
    .mod_o      (mod_y)
  );

  gdcb_div_lane #(.GRID_SIDE(GRID_SIDE)) u_lane_d (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (dist_ext),
    .divisor_i  (divisor),
    .mod_o      (mod_d)
  );

  // Fold: floor modulo for negative quotients, then the diagonal offset.
  logic [IDX_W-1:0] cx, cy, tx_d, ty_d, tx_q, ty_q;
  logic [IDX_W:0]   sx, sy;

  always_comb begin
    cx = (neg_x_q && mod_x != '0) ? IDX_W'(GRID_SIDE) - mod_x : mod_x;
    cy = (neg_y_q && mod_y != '0) ? IDX_W'(GRID_SIDE) - mod_y : mod_y;
    sx = {1'b0, cx} + {1'b0, mod_d};
    sy = {1'b0, cy} + {1'b0, mod_d};
    tx_d = (sx >= (IDX_W+1)'(GRID_SIDE)) ? IDX_W'(sx - (IDX_W+1)'(GRID_SIDE)) : sx[IDX_W-1:0];
    ty_d = (sy >= (IDX_W+1)'(GRID_SIDE)) ? IDX_W'(sy - (IDX_W+1)'(GRID_SIDE)) : sy[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

  // Wrap-around neighbour coordinate along one axis.
  function automatic logic [IDX_W-1:0] wrap_off(input logic [IDX_W-1:0] c,
                                                input logic [1:0] off);
    logic [IDX_W-1:0] r;
    case (off)
      gdcb_pkg::NBR_MINUS: r = (c == '0) ? IDX_W'(GRID_SIDE - 1) : c - IDX_W'(1);
      gdcb_pkg::NBR_PLUS:  r = (c == IDX_W'(GRID_SIDE - 1)) ? '0 : c + IDX_W'(1);
      default:             r = c;
    endcase
    return r;
  endfunction

  logic [IDX_W-1:0]  nx, ny;
  logic [ADDR_W-1:0] rd_addr, tgt_addr, clr_addr_q, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data, rd_data_q, tgt_q;
  logic              mem_we, rd_valid_q, rd_center_q, tgt_inc;

  assign nx       = wrap_off(tx_q, cmd_i.nbr_dx);
  assign ny       = wrap_off(ty_q, cmd_i.nbr_dy);
  assign rd_addr  = ADDR_W'(ADDR_W'(nx) * ADDR_W'(GRID_SIDE) + ADDR_W'(ny));
  assign tgt_addr = ADDR_W'(ADDR_W'(tx_q) * ADDR_W'(GRID_SIDE) + ADDR_W'(ty_q));
  assign tgt_inc  = tgt_q != '1;

  // Single write port shared by the clearing sweep and the counter update.
  assign mem_we  = cmd_i.clr_en || cmd_i.wr_inc;
  assign wr_addr = cmd_i.clr_en ? clr_addr_q : tgt_addr;
  assign wr_data = cmd_i.clr_en ? '0 : (tgt_inc ? tgt_q + COUNT_WIDTH'(1) : tgt_q);

  logic [COUNT_WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      rd_valid_q  <= 1'b0;
      rd_center_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
      end
      rd_valid_q  <= cmd_i.rd_en;
      rd_center_q <= cmd_i.rd_en && cmd_i.nbr_dx == gdcb_pkg::NBR_CENTER
                     && cmd_i.nbr_dy == gdcb_pkg::NBR_CENTER;
    end
  end

  assign sts_o.clr_last = clr_addr_q == ADDR_W'(DEPTH - 1);

  // Neighbourhood sum; the increment of the target joins it at the write.
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (rd_valid_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end else if (cmd_i.wr_inc) begin
      sum_q <= sum_q + SUM_W'(tgt_inc);
    end
    if (rd_center_q) tgt_q <= rd_data_q;
  end

  // Result.
  logic [gdcb_pkg::BIAS_W-1:0] bias;
  logic                        dense;
  gdcb_pkg::out_item_t         res, out_q;

  always_comb begin
    dense = CMP_W'(sum_q) > CMP_W'(threshold_q);
    bias  = gdcb_pkg::BIAS_ONE;
    if (dense) begin
      if (dist_q > far_dist_q) begin
        bias = gdcb_pkg::BIAS_FAR;
      end else if (dist_q > near_dist_q) begin
        bias = gdcb_pkg::BIAS_NEAR;
      end
    end
    res.bias_q8     = bias;
    res.local_count = (CMP_W'(sum_q) > CMP_W'(gdcb_pkg::LCOUNT_MAX))
                    ? gdcb_pkg::LCOUNT_MAX : gdcb_pkg::LCOUNT_W'(sum_q);
    res.target_col  = gdcb_pkg::COORD_W'(tx_q);
    res.target_row  = gdcb_pkg::COORD_W'(ty_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res;
  end

  assign out_item_o = out_q;

  // Writes and reads of the counter memory are scheduled apart.
  a_mem_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_en, cmd_i.wr_inc, cmd_i.rd_en}))
    else $error("overlapping counter memory operations");

  // The folded target cell lies on the grid.
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold |=> (tx_q < IDX_W'(GRID_SIDE - 1) || tx_q == IDX_W'(GRID_SIDE - 1))
                && (ty_q < IDX_W'(GRID_SIDE - 1) || ty_q == IDX_W'(GRID_SIDE - 1)))
    else $error("target cell off the grid");

  // Neighbour reads stay inside the memory.
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (rd_addr < ADDR_W'(DEPTH - 1) || rd_addr == ADDR_W'(DEPTH - 1)))
    else $error("neighbour read outside the grid");

endmodule

`default_nettype wire

// File: rtl/core/grid_density_cull_bias_core.sv
// ----------------------------------------------------------------------------
// Grid density cull bias core
// Wrap-around grid of saturating cell counters that turns viewer position and
// object distance into a cull bias based on local object density.
// ----------------------------------------------------------------------------
// A query beat goes through these steps from acceptance to a loaded result:
// acceptance; division by three restoring divider lanes (viewer x, viewer y
// and distance, each over the cell size) that produce one quotient bit apiece
// per step and reduce it modulo the grid side on the fly; the fold of the
// floor modulo and the diagonal offset; reads of the nine cells of the 3x3
// neighbourhood through the single read port of the counter memory; a wait
// for the last read to land; the write-back of the saturated increment of the
// target cell; and the hand-off of the result to the output register. A frame
// beat clears the grid with a sweep of one counter per cycle through the write
// port over all GRID_SIDE * GRID_SIDE counters (16384 at the default size)
// and gives no result. The same sweep runs right after reset, with
// in_stall_o high, before the first beat is taken. One beat is worked on
// at a time; the next one is accepted as soon as the previous result sits in
// the output register, even while the downstream side still stalls it.
// Configuration writes are always ready and must only be issued while the
// core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_density_cull_bias_core #(
  parameter int GRID_SIDE   = gdcb_pkg::GRID_SIDE_DEF,
  parameter int COUNT_WIDTH = gdcb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input beats.
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire gdcb_pkg::in_item_t               in_item_i,
  // Result beats.
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output gdcb_pkg::out_item_t                   out_item_o,
  // Configuration writes.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gdcb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gdcb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  gdcb_pkg::dp_cmd_t cmd;
  gdcb_pkg::dp_sts_t sts;
  gdcb_pkg::cfg_wr_t cfg_wr;

  // The register file accepts a write in every cycle.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.we    = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // The controller sequences every beat; the datapath holds all storage.
  gdcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdcb_datapath #(
    .GRID_SIDE   (GRID_SIDE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg_wr),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
